[design/dse_pkg.sv]
// ============================================================================
// dse_pkg
// Shared types and constants for the delimited string extractor: transfer
// structs, result kind codes, character constants and the length limit.
// ============================================================================
package dse_pkg;

    // Buffer size: at most MAX_STRING-1 content characters per string
    localparam int MAX_STRING = 64;
    localparam int CNT_W      = $clog2(MAX_STRING);
    localparam int LEN_W      = 6;
    localparam int NEST_W     = 6;

    // Result kinds
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_DONE = 3'd1;
    localparam logic [2:0] KIND_BADQ = 3'd2;
    localparam logic [2:0] KIND_OPEN = 3'd3;
    localparam logic [2:0] KIND_CUT  = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_CARET   = 8'h5E;

    typedef struct packed {
        logic [7:0] ch;
        logic       begin_req;
    } char_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       out_char;
        logic [LEN_W-1:0] length;
    } result_item_t;

    // Low bits of a character count as reported in the length field
    function automatic logic [LEN_W-1:0] count_to_len(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[LEN_W-1:0];
    endfunction

endpackage

[design/delimited_string_extractor.sv]
// ============================================================================
// delimited_string_extractor
// Pulls one delimited string out of a stream of line characters and reports
// its content characters followed by a single completion code.
// ============================================================================
// Usage:
//   Input channel char_*: one line character per transfer; begin_req set on a
//   transfer starts a new extraction at that character and drops any
//   extraction in progress. Output channel result_*: content characters
//   (kind 0) followed by one final code: done with length, bad caret quote,
//   unclosed or too long, or plain run cut with length.
//   A result appears on result_valid in the cycle after the input transfer
//   that caused it. Throughput: one character per cycle while the output is
//   not stalled; the next character is taken in the same cycle the previous
//   result is shown, unless result_stall holds it. Characters that cause no
//   result (blanks, openers, idle input) still take one transfer each.
//   Stall: char_stall is raised only while a result is held and result_stall
//   is high; the held result does not change until it is taken.
//   Reset: the extractor returns to idle and the result register empties.
// ============================================================================
module delimited_string_extractor
    import dse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_item_t   char_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SKIP,
        MODE_CARET,
        MODE_ENCL,
        MODE_PLAIN
    } mode_t;

    localparam logic [CNT_W-1:0]  LIMIT    = CNT_W'(MAX_STRING - 1);
    localparam logic [NEST_W-1:0] NEST_MAX = '1;

    mode_t             mode_reg, mode_next;
    logic [7:0]        open_char_reg, open_char_next;
    logic [7:0]        close_char_reg, close_char_next;
    logic [NEST_W-1:0] nest_level_reg, nest_level_next;
    logic [CNT_W-1:0]  char_count_reg, char_count_next;
    logic              result_valid_reg;
    result_item_t      result_item_reg;

    logic              xfer;
    logic              emit;
    result_item_t      res_next;
    mode_t             mode_eff;
    logic [7:0]        ch;
    logic              is_blank;
    logic              is_delim;
    logic              at_limit;

    // Hold input while a stalled result occupies the output register
    assign char_stall   = result_valid_reg && result_stall;
    assign xfer         = char_valid && !char_stall;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    assign ch       = char_item.ch;
    assign is_blank = ch inside {CH_SPACE, CH_TAB};
    assign is_delim = ch inside {CH_NL, CH_BAR, CH_FF};
    assign at_limit = char_count_reg >= LIMIT;
    assign mode_eff = char_item.begin_req ? MODE_SKIP : mode_reg;

    // Advance the extraction by one character
    always_comb
    begin
        mode_next       = mode_eff;
        open_char_next  = open_char_reg;
        close_char_next = close_char_reg;
        nest_level_next = nest_level_reg;
        char_count_next = char_count_reg;
        emit            = 1'b0;
        res_next        = '{kind: KIND_CHAR, out_char: ch, length: '0};

        case (mode_eff)
            MODE_SKIP:
            begin
                if (!is_blank)
                begin
                    char_count_next = '0;
                    nest_level_next = NEST_W'(1);
                    if (ch inside {CH_LPAREN, CH_LANGLE, CH_DQUOTE})
                    begin
                        open_char_next  = ch;
                        close_char_next = (ch == CH_LPAREN) ? CH_RPAREN :
                                          (ch == CH_LANGLE) ? CH_RANGLE : ch;
                        mode_next       = MODE_ENCL;
                    end
                    else if (ch == CH_CARET)
                    begin
                        mode_next = MODE_CARET;
                    end
                    else if (is_delim)
                    begin
                        mode_next = MODE_IDLE;
                        emit      = 1'b1;
                        res_next  = '{kind: KIND_DONE, out_char: '0, length: '0};
                    end
                    else
                    begin
                        mode_next       = MODE_PLAIN;
                        char_count_next = CNT_W'(1);
                        emit            = 1'b1;
                    end
                end
            end

            MODE_CARET:
            begin
                if (is_delim)
                begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                    res_next  = '{kind: KIND_BADQ, out_char: '0, length: '0};
                end
                else
                begin
                    open_char_next  = ch;
                    close_char_next = ch;
                    nest_level_next = NEST_W'(1);
                    char_count_next = '0;
                    mode_next       = MODE_ENCL;
                end
            end

            MODE_ENCL:
            begin
                emit = 1'b1;
                if (ch == close_char_reg && nest_level_reg <= NEST_W'(1))
                begin
                    mode_next = MODE_IDLE;
                    res_next  = '{kind: KIND_DONE, out_char: '0,
                                  length: count_to_len(char_count_reg)};
                end
                else if (at_limit || (ch != close_char_reg && is_delim))
                begin
                    mode_next = MODE_IDLE;
                    res_next  = '{kind: KIND_OPEN, out_char: '0, length: '0};
                end
                else
                begin
                    if (ch == close_char_reg)
                        nest_level_next = nest_level_reg - NEST_W'(1);
                    else if (ch == open_char_reg && nest_level_reg < NEST_MAX)
                        nest_level_next = nest_level_reg + NEST_W'(1);
                    char_count_next = char_count_reg + CNT_W'(1);
                end
            end

            MODE_PLAIN:
            begin
                emit = 1'b1;
                if (is_blank || is_delim)
                begin
                    mode_next = MODE_IDLE;
                    res_next  = '{kind: KIND_DONE, out_char: '0,
                                  length: count_to_len(char_count_reg)};
                end
                else if (at_limit)
                begin
                    // Drop the character that does not fit
                    mode_next = MODE_IDLE;
                    res_next  = '{kind: KIND_CUT, out_char: '0,
                                  length: count_to_len(char_count_reg)};
                end
                else
                begin
                    char_count_next = char_count_reg + CNT_W'(1);
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // Hold extraction state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            open_char_reg    <= '0;
            close_char_reg   <= '0;
            nest_level_reg   <= '0;
            char_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                mode_reg         <= mode_next;
                open_char_reg    <= open_char_next;
                close_char_reg   <= close_char_next;
                nest_level_reg   <= nest_level_next;
                char_count_reg   <= char_count_next;
                result_valid_reg <= emit;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load result payload on a producing transfer
    always_ff @(posedge clk)
    begin
        if (xfer && emit)
            result_item_reg <= res_next;
    end

    // Input is held back only behind a stalled result
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid)
        else $error("input stalled with empty result register");

    // A content character leaves the extractor inside a string
    a_char_keeps_string: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && emit && res_next.kind == KIND_CHAR) |=>
            (mode_reg == MODE_ENCL || mode_reg == MODE_PLAIN))
        else $error("content character emitted outside a string");

    // A final code returns the extractor to idle
    a_final_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && emit && res_next.kind != KIND_CHAR) |=> mode_reg == MODE_IDLE)
        else $error("final code without return to idle");

    // Enclosed strings always keep an open nesting level
    a_nest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ENCL |-> nest_level_reg != '0)
        else $error("enclosed string with zero nesting level");

    // Length is reported only with done and cut codes
    a_length_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.kind != KIND_DONE && result_item.kind != KIND_CUT)
            |-> result_item.length == '0)
        else $error("length reported with wrong kind");

endmodule
